// File: src/assert_macros.svh
// Assertion helpers for the I2C bit sequencer.
// They expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// File: src/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

    // Command codes; the idle phase shares the "none" code
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_SACK  = 3'd3;
    localparam logic [2:0] OP_RACK  = 3'd4;
    localparam logic [2:0] OP_SBYTE = 3'd5;
    localparam logic [2:0] OP_RBYTE = 3'd6;
    localparam logic [2:0] PH_IDLE  = OP_NONE;

    localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd200;

    // Last step counts of the byte commands
    localparam logic [4:0] SBYTE_LAST_STEP = 5'd23;
    localparam logic [4:0] RBYTE_LAST_STEP = 5'd16;
    // Step at which receive ack drops SCL
    localparam logic [4:0] RACK_END_STEP   = 5'd3;

    typedef struct packed {
        logic [2:0] phase;
        logic [4:0] bit_step;
        logic [1:0] sub_step;     // bit_step mod 3 during send byte
        logic [7:0] shift_out;
        logic [7:0] shift_in;
        logic [7:0] poll_count;
        logic       ack_result;
        logic       ack_latched;
        logic       scl_drive;
        logic       sda_drive;
    } seq_state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       command_done;
        logic       command_accepted;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } seq_result_t;

endpackage

// File: src/i2cms_step.sv
`timescale 1ns / 1ps

// One tick of the line sequencer: current state and input word in,
// next state and result word out.
module i2cms_step (
    input  i2cms_pkg::seq_state_t  state_cur,
    input  logic [7:0]             ack_poll_limit,
    input  logic [2:0]             opcode,
    input  logic [7:0]             tx_byte,
    input  logic                   ack_to_send,
    input  logic                   sda_in,
    output i2cms_pkg::seq_state_t  state_nxt,
    output i2cms_pkg::seq_result_t result
);
    import i2cms_pkg::*;

    logic [7:0] poll_inc;
    logic       accepted;
    logic       last;
    logic       step_inc;

    assign poll_inc = state_cur.poll_count + 8'd1;

    always_comb begin
        state_nxt = state_cur;
        accepted  = 1'b0;
        last      = 1'b0;
        step_inc  = 1'b1;

        // Command start, only from idle
        if (state_cur.phase == PH_IDLE && opcode >= OP_START && opcode <= OP_RBYTE) begin
            state_nxt.phase       = opcode;
            state_nxt.bit_step    = 5'd0;
            state_nxt.sub_step    = 2'd0;
            state_nxt.shift_out   = tx_byte;
            state_nxt.ack_latched = ack_to_send;
            state_nxt.poll_count  = 8'd0;
            accepted              = 1'b1;
        end

        // Line step of the running command
        case (state_nxt.phase)
            PH_IDLE: begin
                step_inc = 1'b0;
            end
            OP_START: begin
                case (state_nxt.bit_step)
                    5'd0:    state_nxt.sda_drive = 1'b1;
                    5'd1:    state_nxt.scl_drive = 1'b1;
                    5'd2:    state_nxt.sda_drive = 1'b0;
                    default: begin
                        state_nxt.scl_drive = 1'b0;
                        last = 1'b1;
                    end
                endcase
            end
            OP_STOP: begin
                case (state_nxt.bit_step)
                    5'd0:    state_nxt.scl_drive = 1'b0;
                    5'd1:    state_nxt.sda_drive = 1'b0;
                    5'd2:    state_nxt.scl_drive = 1'b1;
                    default: begin
                        state_nxt.sda_drive = 1'b1;
                        last = 1'b1;
                    end
                endcase
            end
            OP_SACK: begin
                case (state_nxt.bit_step)
                    5'd0:    state_nxt.sda_drive = state_nxt.ack_latched;
                    5'd1:    state_nxt.scl_drive = 1'b1;
                    default: begin
                        state_nxt.scl_drive = 1'b0;
                        last = 1'b1;
                    end
                endcase
            end
            OP_RACK: begin
                case (state_nxt.bit_step)
                    5'd0: state_nxt.sda_drive = 1'b1;
                    5'd1: state_nxt.scl_drive = 1'b1;
                    5'd2: begin
                        // Poll tick: step holds until ack or timeout
                        step_inc = 1'b0;
                        if (!sda_in) begin
                            state_nxt.ack_result = 1'b0;
                            state_nxt.bit_step   = RACK_END_STEP;
                        end else begin
                            state_nxt.poll_count = poll_inc;
                            if (poll_inc >= ack_poll_limit || poll_inc == 8'd0) begin
                                state_nxt.ack_result = 1'b1;
                                state_nxt.bit_step   = RACK_END_STEP;
                            end
                        end
                    end
                    default: begin
                        state_nxt.scl_drive = 1'b0;
                        last = 1'b1;
                    end
                endcase
            end
            OP_SBYTE: begin
                case (state_nxt.sub_step)
                    2'd0: state_nxt.sda_drive = state_nxt.shift_out[7];
                    2'd1: state_nxt.scl_drive = 1'b1;
                    default: begin
                        state_nxt.scl_drive = 1'b0;
                        state_nxt.shift_out = {state_nxt.shift_out[6:0], 1'b0};
                        if (state_nxt.bit_step >= SBYTE_LAST_STEP) begin
                            last = 1'b1;
                        end
                    end
                endcase
                state_nxt.sub_step = (state_nxt.sub_step == 2'd2) ? 2'd0
                                                                  : state_nxt.sub_step + 2'd1;
            end
            OP_RBYTE: begin
                if (state_nxt.bit_step == 5'd0) begin
                    state_nxt.sda_drive = 1'b1;
                end else if (state_nxt.bit_step[0]) begin
                    // SCL high: sample SDA into the LSB
                    state_nxt.scl_drive = 1'b1;
                    state_nxt.shift_in  = {state_nxt.shift_in[6:0], sda_in};
                end else begin
                    state_nxt.scl_drive = 1'b0;
                    if (state_nxt.bit_step >= RBYTE_LAST_STEP) begin
                        last = 1'b1;
                    end
                end
            end
            default: begin
                last = 1'b1;
            end
        endcase

        if (step_inc) begin
            state_nxt.bit_step = state_nxt.bit_step + 5'd1;
        end
        if (last) begin
            state_nxt.phase    = PH_IDLE;
            state_nxt.bit_step = 5'd0;
        end
    end

    // Result word for this tick
    always_comb begin
        result.scl_level        = state_nxt.scl_drive;
        result.sda_level        = state_nxt.sda_drive;
        result.busy_res         = (state_nxt.phase != PH_IDLE);
        result.command_done     = last;
        result.command_accepted = accepted;
        result.rx_byte          = state_nxt.shift_in;
        result.ack_seen         = state_nxt.ack_result;
    end

endmodule

// File: src/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps

// I2C master line sequencer. Every input word is one tick and yields exactly one
// result word holding the SCL/SDA open-drain drive levels after that tick, busy,
// done and accepted flags, the receive shift register and the last ack result.
// Opcodes 1 to 6 start a command only while idle; its first line step happens
// on the same tick. One word is taken per clock cycle: the tick logic sits between
// the state registers and a single output register, and s_ready is high whenever
// that register is empty or being read. Start and stop take 4 ticks, send ack 3,
// receive ack 3 plus 1 to ack_poll_limit poll ticks (a limit of zero acts as one),
// send byte 24 and receive byte 17. cfg_wr_en writes ack_poll_limit (reset 200);
// write it only while idle.
module i2c_master_bit_sequencer (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // tick input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [7:0] s_tx_byte,
    input  logic       s_ack_to_send,
    input  logic       s_sda_in,
    // tick result
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_busy_res,
    output logic       m_command_done,
    output logic       m_command_accepted,
    output logic [7:0] m_rx_byte,
    output logic       m_ack_seen
);
    import i2cms_pkg::*;

    `include "assert_macros.svh"

    logic [7:0]  ack_poll_limit_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_result_t result_next;
    seq_result_t result_reg;
    logic        m_valid_reg;
    logic        s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Poll limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_poll_limit_reg <= ACK_POLL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            ack_poll_limit_reg <= cfg_wr_data;
        end
    end

    i2cms_step u_step (
        .state_cur      (state_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .opcode         (s_opcode),
        .tx_byte        (s_tx_byte),
        .ack_to_send    (s_ack_to_send),
        .sda_in         (s_sda_in),
        .state_nxt      (state_next),
        .result         (result_next)
    );

    // Sequencer state, advanced once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= PH_IDLE;
            state_reg.bit_step    <= 5'd0;
            state_reg.sub_step    <= 2'd0;
            state_reg.shift_out   <= 8'd0;
            state_reg.shift_in    <= 8'd0;
            state_reg.poll_count  <= 8'd0;
            state_reg.ack_result  <= 1'b1;
            state_reg.ack_latched <= 1'b0;
            state_reg.scl_drive   <= 1'b1;
            state_reg.sda_drive   <= 1'b1;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_scl_level        = result_reg.scl_level;
    assign m_sda_level        = result_reg.sda_level;
    assign m_busy_res         = result_reg.busy_res;
    assign m_command_done     = result_reg.command_done;
    assign m_command_accepted = result_reg.command_accepted;
    assign m_rx_byte          = result_reg.rx_byte;
    assign m_ack_seen         = result_reg.ack_seen;

    // Checks
    `ASSERT_PROP(a_start_taken, aclk, aresetn, (s_accept && state_reg.phase == PH_IDLE && s_opcode >= OP_START && s_opcode <= OP_RBYTE) |=> (m_valid && m_command_accepted))
    `ASSERT_PROP(a_busy_ignored, aclk, aresetn, (s_accept && state_reg.phase != PH_IDLE) |=> !m_command_accepted)
    `ASSERT_PROP(a_busy_matches, aclk, aresetn, m_valid_reg |-> (m_busy_res == (state_reg.phase != PH_IDLE)))
    `ASSERT_NEVER(a_idle_step, aclk, aresetn, state_reg.phase == PH_IDLE && state_reg.bit_step != 5'd0)
    `ASSERT_NEVER(a_sbyte_range, aclk, aresetn, state_reg.phase == OP_SBYTE && state_reg.bit_step > SBYTE_LAST_STEP)

endmodule
